// ===== src/wpr_pkg.sv =====
// Package with types, codes and constants shared by the written page range tracker.
package wpr_pkg;

    // Table geometry and default sizes.
    localparam int PAGE_SLOTS_DEF = 32;
    localparam int KEY_W          = 60;
    localparam int ADDR_W         = 64;
    localparam int COUNT_W        = 22;

    // Page size register limits and reset value.
    localparam logic [4:0] LG_RESET = 5'd12;
    localparam logic [4:0] LG_MIN   = 5'd4;
    localparam logic [4:0] LG_MAX   = 5'd16;

    // Register word index of the page size register.
    localparam logic REG_PAGE_SIZE_LOG2 = 1'b0;

    // Input operation codes.
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Result kind codes.
    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_REGION = 2'd1;
    localparam logic [1:0] KIND_TOTAL  = 2'd2;

    // Store status codes.
    localparam logic [1:0] STATUS_NEW     = 2'd0;
    localparam logic [1:0] STATUS_PRESENT = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // Input transfer payload.
    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
    } wpr_in_t;

    // Result transfer payload.
    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         status;
        logic [ADDR_W-1:0]  region_start;
        logic [ADDR_W-1:0]  region_end;
        logic [COUNT_W-1:0] byte_count;
        logic               last;
    } wpr_out_t;

    // Control handed to every cell of the page chain.
    typedef struct packed {
        logic insert;
        logic rotate;
    } wpr_cell_ctrl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT,
        ST_SPIN,
        ST_TOTAL
    } wpr_state_t;

endpackage

// ===== src/wpr_cell.sv =====
// One cell of the sorted page chain: holds one page key and shifts or rotates it.
module wpr_cell (
    input  logic                          aclk,
    input  wpr_pkg::wpr_cell_ctrl_t       ctrl,
    input  logic [wpr_pkg::KEY_W-1:0]     new_key,
    input  logic [wpr_pkg::KEY_W-1:0]     prev_key,
    input  logic [wpr_pkg::KEY_W-1:0]     succ_key,
    input  logic                          prev_lt,
    input  logic                          occupied,
    output logic [wpr_pkg::KEY_W-1:0]     key,
    output logic                          lt,
    output logic                          eq
);

    logic [wpr_pkg::KEY_W-1:0] key_reg;
    logic [wpr_pkg::KEY_W-1:0] key_next;

    // Local compare against the incoming key.
    assign lt  = occupied && (key_reg < new_key);
    assign eq  = occupied && (key_reg == new_key);
    assign key = key_reg;

    // A cell at or above the insert point takes the new key or its lower neighbor's key.
    always_comb begin
        priority if (ctrl.rotate) begin
            key_next = succ_key;
        end else if (ctrl.insert && !lt) begin
            key_next = prev_lt ? new_key : prev_key;
        end else begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// ===== src/wpr_out_queue.sv =====
// Two-entry result queue that parts the sequencer from the result channel.
module wpr_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  wpr_pkg::wpr_out_t push_data,
    output logic              full,
    output logic              m_valid,
    input  logic              m_ready,
    output wpr_pkg::wpr_out_t m_data
);

    wpr_pkg::wpr_out_t head_reg;
    wpr_pkg::wpr_out_t head_next;
    wpr_pkg::wpr_out_t tail_reg;
    wpr_pkg::wpr_out_t tail_next;
    logic              head_v_reg;
    logic              head_v_next;
    logic              tail_v_reg;
    logic              tail_v_next;
    logic              pop;

    assign pop     = head_v_reg && m_ready;
    assign full    = tail_v_reg;
    assign m_valid = head_v_reg;
    assign m_data  = head_reg;

    // Refill the head from the tail or from the pushed result.
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        head_v_next = head_v_reg;
        tail_v_next = tail_v_reg;
        if (pop) begin
            if (tail_v_reg) begin
                head_next   = tail_reg;
                tail_next   = push_data;
                tail_v_next = push;
            end else begin
                head_next   = push_data;
                head_v_next = push;
            end
        end else if (!head_v_reg) begin
            head_next   = push_data;
            head_v_next = push;
        end else if (push) begin
            tail_next   = push_data;
            tail_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
        end else begin
            head_v_reg <= head_v_next;
            tail_v_reg <= tail_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ===== src/written_page_range_tracker_top.sv =====
// Top level of the written page range tracker: register port, page chain and sequencer.
//
//  Channel   Ports               Moves
//  config    psel..prdata        page_size_log2 register, APB-style write and read
//  input     s_valid/s_ready     one store or report request per transfer
//  result    m_valid/m_ready     store status, region and total results
//
// In a store every cell compares its key at once and the chain shifts to insert, so
// stores go through at one per cycle while no report runs and the result queue drains.
// After the accepting cycle a report rotates the whole chain through cell 0: each held
// page is evaluated and emitted, with a region result where a region closes; each empty
// slot (PAGE_SLOTS - n) is spun past; the total is last. An empty table skips the walk.
// No clearing pass follows reset; only page count, page size and control state are reset.
// A full result queue holds any step that pushes; the chain stands still while it waits.
module written_page_range_tracker_top #(
    parameter int PAGE_SLOTS = wpr_pkg::PAGE_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  wpr_pkg::wpr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output wpr_pkg::wpr_out_t m_data
);

    localparam int CW       = $clog2(PAGE_SLOTS + 1);
    localparam int NEXT_IDX = (PAGE_SLOTS > 1) ? 1 : 0;
    localparam int KW       = wpr_pkg::KEY_W;
    localparam int AW       = wpr_pkg::ADDR_W;
    localparam int NW       = wpr_pkg::COUNT_W;

    logic [4:0]               lg_reg;
    logic [4:0]               lg_eff;
    logic [AW-1:0]            psize;
    logic [KW-1:0]            key_mask;
    logic [KW-1:0]            new_key;

    wpr_pkg::wpr_state_t      state_reg;
    wpr_pkg::wpr_state_t      state_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            idx_reg;
    logic [CW-1:0]            idx_inc;
    logic [AW-1:0]            first_reg;
    logic [AW-1:0]            end_reg;
    logic                     close_reg;
    logic [NW-1:0]            total_reg;

    logic [KW-1:0]            cell_key [PAGE_SLOTS];
    logic [PAGE_SLOTS-1:0]    lt_vec;
    logic [PAGE_SLOTS-1:0]    eq_vec;
    wpr_pkg::wpr_cell_ctrl_t  cell_ctrl;

    logic                     in_acc;
    logic                     is_store;
    logic                     present;
    logic                     table_full;
    logic                     step_go;
    logic [AW-1:0]            cur_addr;
    logic [AW-1:0]            next_addr;
    logic [AW-1:0]            cur_end;
    logic [AW-1:0]            size64;
    logic [NW-1:0]            size_sat;
    logic [NW:0]              total_sum;
    logic [NW-1:0]            total_sat;
    logic                     q_full;
    logic                     push;
    wpr_pkg::wpr_out_t        push_data;

    // Register port: one word, writes land on the access cycle.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == wpr_pkg::REG_PAGE_SIZE_LOG2) ? {27'd0, lg_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lg_reg <= wpr_pkg::LG_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == wpr_pkg::REG_PAGE_SIZE_LOG2) begin
            lg_reg <= pwdata[4:0];
        end
    end

    // Page size, saturated into its legal range, and the aligned key of a store.
    always_comb begin
        priority if (lg_reg < wpr_pkg::LG_MIN) begin
            lg_eff = wpr_pkg::LG_MIN;
        end else if (lg_reg > wpr_pkg::LG_MAX) begin
            lg_eff = wpr_pkg::LG_MAX;
        end else begin
            lg_eff = lg_reg;
        end
    end

    assign psize    = AW'(1) << lg_eff;
    assign key_mask = ~((KW'(1) << (lg_eff - wpr_pkg::LG_MIN)) - KW'(1));
    assign new_key  = s_data.address[AW-1:4] & key_mask;

    // The chain of page cells, kept in ascending key order from cell 0 up.
    for (genvar i = 0; i < PAGE_SLOTS; i++) begin : g_cell
        localparam int SUCC = (i + 1) % PAGE_SLOTS;
        logic [KW-1:0] prev_key;
        logic          prev_lt;
        if (i == 0) begin : g_first
            assign prev_key = new_key;
            assign prev_lt  = 1'b1;
        end else begin : g_rest
            assign prev_key = cell_key[i-1];
            assign prev_lt  = lt_vec[i-1];
        end
        wpr_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .new_key  (new_key),
            .prev_key (prev_key),
            .succ_key (cell_key[SUCC]),
            .prev_lt  (prev_lt),
            .occupied (CW'(i) < count_reg),
            .key      (cell_key[i]),
            .lt       (lt_vec[i]),
            .eq       (eq_vec[i])
        );
    end

    assign present    = |eq_vec;
    assign table_full = (count_reg == CW'(PAGE_SLOTS));
    assign is_store   = (s_data.operation == wpr_pkg::OP_STORE);
    assign s_ready    = (state_reg == wpr_pkg::ST_IDLE) && !q_full;
    assign in_acc     = s_valid && s_ready;
    assign idx_inc    = idx_reg + CW'(1);
    assign step_go    = !close_reg || !q_full;

    // Region arithmetic on the page now in cell 0 and its successor in cell 1.
    assign cur_addr  = {cell_key[0], 4'd0};
    assign next_addr = {cell_key[NEXT_IDX], 4'd0};
    assign cur_end   = cur_addr + psize;
    assign size64    = end_reg - first_reg;
    assign size_sat  = (|size64[AW-1:NW]) ? {NW{1'b1}} : size64[NW-1:0];
    assign total_sum = {1'b0, total_reg} + {1'b0, size_sat};
    assign total_sat = total_sum[NW] ? {NW{1'b1}} : total_sum[NW-1:0];

    // Next state of the report sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wpr_pkg::ST_IDLE: begin
                if (in_acc && !is_store) begin
                    state_next = (count_reg == '0) ? wpr_pkg::ST_TOTAL : wpr_pkg::ST_EVAL;
                end
            end
            wpr_pkg::ST_EVAL: begin
                state_next = wpr_pkg::ST_EMIT;
            end
            wpr_pkg::ST_EMIT: begin
                if (step_go) begin
                    if (idx_inc == count_reg) begin
                        state_next = table_full ? wpr_pkg::ST_TOTAL : wpr_pkg::ST_SPIN;
                    end else begin
                        state_next = wpr_pkg::ST_EVAL;
                    end
                end
            end
            wpr_pkg::ST_SPIN: begin
                if (idx_inc == CW'(PAGE_SLOTS)) begin
                    state_next = wpr_pkg::ST_TOTAL;
                end
            end
            wpr_pkg::ST_TOTAL: begin
                if (!q_full) begin
                    state_next = wpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: chain control and the result pushed into the queue.
    always_comb begin
        cell_ctrl = '0;
        push      = 1'b0;
        push_data = '0;
        unique case (state_reg)
            wpr_pkg::ST_IDLE: begin
                if (in_acc && is_store) begin
                    push             = 1'b1;
                    push_data.kind   = wpr_pkg::KIND_STORE;
                    push_data.last   = 1'b1;
                    cell_ctrl.insert = !present && !table_full;
                    priority if (present) begin
                        push_data.status = wpr_pkg::STATUS_PRESENT;
                    end else if (table_full) begin
                        push_data.status = wpr_pkg::STATUS_FULL;
                    end else begin
                        push_data.status = wpr_pkg::STATUS_NEW;
                    end
                end
            end
            wpr_pkg::ST_EVAL: begin
                cell_ctrl = '0;
            end
            wpr_pkg::ST_EMIT: begin
                cell_ctrl.rotate       = step_go;
                push                   = close_reg && !q_full;
                push_data.kind         = wpr_pkg::KIND_REGION;
                push_data.region_start = first_reg;
                push_data.region_end   = end_reg;
                push_data.byte_count   = size_sat;
            end
            wpr_pkg::ST_SPIN: begin
                cell_ctrl.rotate = 1'b1;
            end
            wpr_pkg::ST_TOTAL: begin
                push                 = !q_full;
                push_data.kind       = wpr_pkg::KIND_TOTAL;
                push_data.byte_count = total_reg;
                push_data.last       = 1'b1;
            end
            default: begin
                cell_ctrl = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wpr_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cell_ctrl.insert) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Report walk registers: region start, end, closing flag, position and total.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            wpr_pkg::ST_IDLE: begin
                first_reg <= cur_addr;
                total_reg <= '0;
                idx_reg   <= '0;
            end
            wpr_pkg::ST_EVAL: begin
                end_reg   <= cur_end;
                close_reg <= (idx_inc == count_reg) || (next_addr > cur_end);
            end
            wpr_pkg::ST_EMIT: begin
                if (step_go) begin
                    idx_reg <= idx_inc;
                    if (close_reg) begin
                        total_reg <= total_sat;
                        first_reg <= next_addr;
                    end
                end
            end
            wpr_pkg::ST_SPIN: begin
                idx_reg <= idx_inc;
            end
            wpr_pkg::ST_TOTAL: begin
                idx_reg <= idx_reg;
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // Result queue toward the result channel.
    wpr_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== src/wpr_checker.sv =====
// Port-level checker for the written page range tracker, bound to the top level.
module wpr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input wpr_pkg::wpr_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input wpr_pkg::wpr_out_t m_data
);

    // A stalled result transfer keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A store transfer is always followed in the next cycle by a valid result.
    a_store_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == wpr_pkg::OP_STORE |=> m_valid)
        else $error("store status missing");

    // Only region results are followed by more results of the same request.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.kind != wpr_pkg::KIND_REGION)))
        else $error("last flag does not match result kind");

    // Reset empties the result side.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind written_page_range_tracker_top wpr_checker u_wpr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
